// ----- rtl/ips_patch_stream_parser_defines.svh -----
// assertion macros for the patch stream parser
// expects clk and rst_n in the scope of each use
`ifndef IPS_PATCH_STREAM_PARSER_DEFINES_SVH
`define IPS_PATCH_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IPS_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("patch parser check failed");

// next-cycle implication, checked out of reset
`define IPS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("patch parser check failed");

`endif

// ----- rtl/ips_psp_pkg.sv -----
// shared types and constants of the patch stream parser
// no dependencies
package ips_psp_pkg;

    localparam int ADDR_W  = 25;
    localparam int OFFS_W  = 24;
    localparam int LEN_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

    // offset bytes that end the patch
    localparam logic [OFFS_W-1:0] EOF_MARK = 24'h454F46;

    localparam logic [ADDR_W-1:0] BASE_SIZE_RESET = '0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  run_count;
        logic [ADDR_W-1:0] image_size;
    } result_t;

    // expected header text, one character per position
    function automatic logic [BYTE_W-1:0] header_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h41;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h43;
            default: c = 8'h48;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/ips_patch_stream_parser.sv -----
// IPS patch stream parser: header check, record parsing, write, fill, end and bad-header results
// depends on ips_psp_pkg and ips_patch_stream_parser_defines.svh
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    file_byte
//  result    out        out_valid / out_stall  kind, address, value, run_count, image_size
//  config    in         cfg_valid / cfg_ready  cfg_data (base_size)
//
// one byte a cycle sustained while the result side does not stall; a byte waits in
// the input register and its result, if any, is registered in the result register.
// the parser state update is a single pass of logic between the two registers.
// reset clears the parser state and valid flags and loads base_size with BASE_RESET; no clearing pass.
// a stalled result holds the input register, and in_stall rises only then.
`include "ips_patch_stream_parser_defines.svh"

module ips_patch_stream_parser #(
    parameter logic [ips_psp_pkg::ADDR_W-1:0] BASE_RESET = ips_psp_pkg::BASE_SIZE_RESET
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ips_psp_pkg::BYTE_W-1:0]     file_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ips_psp_pkg::KIND_W-1:0]     kind,
    output logic [ips_psp_pkg::ADDR_W-1:0]     address,
    output logic [ips_psp_pkg::BYTE_W-1:0]     value,
    output logic [ips_psp_pkg::LEN_W-1:0]      run_count,
    output logic [ips_psp_pkg::ADDR_W-1:0]     image_size,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ips_psp_pkg::ADDR_W-1:0]     cfg_data
);

    localparam int OW = ips_psp_pkg::OFFS_W;
    localparam int LW = ips_psp_pkg::LEN_W;
    localparam int AW = ips_psp_pkg::ADDR_W;
    localparam int BW = ips_psp_pkg::BYTE_W;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_OFFSET = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_RLE    = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [AW-1:0]        base_size_reg;
    logic                 s1_valid_reg;
    logic [BW-1:0]        byte_reg;
    logic [2:0]           phase_reg, phase_next;
    logic [2:0]           idx_reg, idx_next;
    logic [OW-1:0]        offset_reg, offset_next;
    logic [LW-1:0]        length_reg, length_next;
    logic [LW-1:0]        done_reg, done_next;
    logic [AW-1:0]        highest_reg, highest_next;
    logic                 match_reg, match_next;
    logic                 out_valid_reg;
    ips_psp_pkg::result_t res_reg, res_next;
    logic                 emit;
    logic                 proc;
    logic                 match_now;
    logic [OW-1:0]        off_shift;
    logic [LW-1:0]        len_shift;
    logic [LW-1:0]        done_inc;
    logic                 note;
    logic [LW-1:0]        end_len;
    logic [AW-1:0]        end_sum;
    logic [AW-1:0]        size_now;

    // the byte in the input register moves on when the result slot is free
    assign proc      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !proc;
    assign cfg_ready = 1'b1;

    // outputs
    assign out_valid  = out_valid_reg;
    assign kind       = res_reg.kind;
    assign address    = res_reg.address;
    assign value      = res_reg.value;
    assign run_count  = res_reg.run_count;
    assign image_size = res_reg.image_size;

    // shifted fields and record end
    assign match_now = match_reg && (byte_reg == ips_psp_pkg::header_char(idx_reg));
    assign off_shift = {offset_reg[OW-BW-1:0], byte_reg};
    assign len_shift = {length_reg[LW-BW-1:0], byte_reg};
    assign done_inc  = done_reg + LW'(1);
    assign end_len   = (phase_reg == PH_LENGTH) ? len_shift : length_reg;
    assign end_sum   = {1'b0, offset_reg} + {{(AW-LW){1'b0}}, end_len};
    assign highest_next = (proc && note && (end_sum > highest_reg)) ? end_sum : highest_reg;
    assign size_now  = (base_size_reg > highest_next) ? base_size_reg : highest_next;

    // parser state update
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        offset_next = offset_reg;
        length_next = length_reg;
        done_next   = done_reg;
        match_next  = match_reg;
        note        = 1'b0;
        emit        = 1'b0;
        res_next.kind       = ips_psp_pkg::KIND_WRITE;
        res_next.address    = '0;
        res_next.value      = '0;
        res_next.run_count  = '0;
        res_next.image_size = size_now;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (idx_reg == 3'd4)
                begin
                    idx_next = '0;
                    if (!match_now)
                    begin
                        phase_next    = PH_DONE;
                        match_next    = 1'b0;
                        emit          = 1'b1;
                        res_next.kind = ips_psp_pkg::KIND_BAD;
                    end
                    else
                    begin
                        phase_next  = PH_OFFSET;
                        offset_next = '0;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    match_next = match_now;
                end
            end
            PH_OFFSET:
            begin
                offset_next = off_shift;
                if (idx_reg == 3'd2)
                begin
                    idx_next = '0;
                    if (off_shift == ips_psp_pkg::EOF_MARK)
                    begin
                        phase_next    = PH_DONE;
                        emit          = 1'b1;
                        res_next.kind = ips_psp_pkg::KIND_END;
                    end
                    else
                    begin
                        phase_next  = PH_LENGTH;
                        length_next = '0;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_LENGTH:
            begin
                length_next = len_shift;
                if (idx_reg == 3'd1)
                begin
                    idx_next  = '0;
                    done_next = '0;
                    if (len_shift == '0)
                    begin
                        phase_next = PH_RLE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        note       = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_DATA:
            begin
                done_next = done_inc;
                if (done_inc >= length_reg)
                begin
                    phase_next  = PH_OFFSET;
                    offset_next = '0;
                    done_next   = '0;
                end
                emit             = 1'b1;
                res_next.kind    = ips_psp_pkg::KIND_WRITE;
                res_next.address = {1'b0, offset_reg} + {{(AW-LW){1'b0}}, done_reg};
                res_next.value   = byte_reg;
            end
            PH_RLE:
            begin
                if (idx_reg < 3'd2)
                begin
                    length_next = len_shift;
                    idx_next    = idx_reg + 3'd1;
                end
                else
                begin
                    idx_next           = '0;
                    phase_next         = PH_OFFSET;
                    offset_next        = '0;
                    note               = 1'b1;
                    emit               = 1'b1;
                    res_next.kind      = ips_psp_pkg::KIND_FILL;
                    res_next.address   = {1'b0, offset_reg};
                    res_next.value     = byte_reg;
                    res_next.run_count = length_reg;
                end
            end
            default:
            begin
                // patch ended or bad header: bytes are dropped
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg <= BASE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            idx_reg       <= '0;
            offset_reg    <= '0;
            length_reg    <= '0;
            done_reg      <= '0;
            highest_reg   <= '0;
            match_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_size_reg <= cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                out_valid_reg <= emit;
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                offset_reg    <= offset_next;
                length_reg    <= length_next;
                done_reg      <= done_next;
                highest_reg   <= highest_next;
                match_reg     <= match_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= file_byte;
        end
        if (proc && emit)
        begin
            res_reg <= res_next;
        end
    end

    // checks on the parser
    `IPS_ASSERT_NEXT(a_done_sticky, phase_reg == PH_DONE, phase_reg == PH_DONE)
    `IPS_ASSERT_NOW(a_write_no_count, out_valid && kind == ips_psp_pkg::KIND_WRITE, run_count == '0)
    `IPS_ASSERT_NOW(a_size_floor, out_valid_reg, image_size >= base_size_reg)
    `IPS_ASSERT_NOW(a_index_range, 1'b1, idx_reg < 3'd5)

endmodule

// ----- tb/ips_psp_result_checker.sv -----
`timescale 1ns / 1ps
// result checker for the patch stream parser: follows the byte requests with
// its own parser, queues the results they imply and compares the result channel
// depends on ips_psp_pkg
module ips_psp_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [ips_psp_pkg::BYTE_W-1:0] file_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [ips_psp_pkg::KIND_W-1:0] kind,
    input  logic [ips_psp_pkg::ADDR_W-1:0] address,
    input  logic [ips_psp_pkg::BYTE_W-1:0] value,
    input  logic [ips_psp_pkg::LEN_W-1:0]  run_count,
    input  logic [ips_psp_pkg::ADDR_W-1:0] image_size,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ips_psp_pkg::ADDR_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             results_due
);

    localparam logic [39:0] MAGIC = "PATCH";

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_OFFSET,
        ST_LENGTH,
        ST_DATA,
        ST_RUN,
        ST_DONE
    } parse_state_t;

    // parser copy
    parse_state_t                   st = ST_HEADER;
    logic [2:0]                     field_idx = '0;
    logic [ips_psp_pkg::OFFS_W-1:0] rec_offset = '0;
    logic [ips_psp_pkg::LEN_W-1:0]  rec_len = '0;
    logic [ips_psp_pkg::LEN_W-1:0]  data_done = '0;
    logic [ips_psp_pkg::ADDR_W-1:0] highest_end = '0;
    logic                           header_ok = 1'b1;
    logic [ips_psp_pkg::ADDR_W-1:0] base_size = ips_psp_pkg::BASE_SIZE_RESET;

    ips_psp_pkg::result_t patch_results_due[$];
    int                   fails = 0;

    // 25-bit sum of a 24-bit offset and a 16-bit length
    function automatic logic [ips_psp_pkg::ADDR_W-1:0] offset_plus(
        input logic [ips_psp_pkg::OFFS_W-1:0] offs,
        input logic [ips_psp_pkg::LEN_W-1:0]  len);
        return {1'b0, offs} + {{(ips_psp_pkg::ADDR_W-ips_psp_pkg::LEN_W){1'b0}}, len};
    endfunction

    task automatic note_record_end(input logic [ips_psp_pkg::ADDR_W-1:0] rec_end);
        if (rec_end > highest_end)
        begin
            highest_end = rec_end;
        end
    endtask

    task automatic queue_result(input logic [ips_psp_pkg::KIND_W-1:0] k,
                                input logic [ips_psp_pkg::ADDR_W-1:0] a,
                                input logic [ips_psp_pkg::BYTE_W-1:0] v,
                                input logic [ips_psp_pkg::LEN_W-1:0]  n);
        ips_psp_pkg::result_t r;
        r.kind       = k;
        r.address    = a;
        r.value      = v;
        r.run_count  = n;
        r.image_size = (base_size > highest_end) ? base_size : highest_end;
        patch_results_due = {patch_results_due, r};
    endtask

    // advance the parser by one file byte
    task automatic parse_patch_byte(input logic [ips_psp_pkg::BYTE_W-1:0] b);
        logic [ips_psp_pkg::ADDR_W-1:0] wr_addr;
        case (st)
            ST_HEADER:
            begin
                if (b != MAGIC[8*(4-field_idx) +: 8])
                begin
                    header_ok = 1'b0;
                end
                if (field_idx == 3'd4)
                begin
                    field_idx = '0;
                    if (!header_ok)
                    begin
                        st = ST_DONE;
                        queue_result(ips_psp_pkg::KIND_BAD, '0, '0, '0);
                    end
                    else
                    begin
                        st = ST_OFFSET;
                        rec_offset = '0;
                    end
                end
                else
                begin
                    field_idx = field_idx + 3'd1;
                end
            end
            ST_OFFSET:
            begin
                rec_offset = {rec_offset[ips_psp_pkg::OFFS_W-9:0], b};
                if (field_idx == 3'd2)
                begin
                    field_idx = '0;
                    if (rec_offset == ips_psp_pkg::EOF_MARK)
                    begin
                        st = ST_DONE;
                        queue_result(ips_psp_pkg::KIND_END, '0, '0, '0);
                    end
                    else
                    begin
                        st = ST_LENGTH;
                        rec_len = '0;
                    end
                end
                else
                begin
                    field_idx = field_idx + 3'd1;
                end
            end
            ST_LENGTH:
            begin
                rec_len = {rec_len[7:0], b};
                if (field_idx == 3'd1)
                begin
                    field_idx = '0;
                    data_done = '0;
                    if (rec_len == '0)
                    begin
                        st = ST_RUN;
                    end
                    else
                    begin
                        // data record end counts as soon as the length is known
                        st = ST_DATA;
                        note_record_end(offset_plus(rec_offset, rec_len));
                    end
                end
                else
                begin
                    field_idx = field_idx + 3'd1;
                end
            end
            ST_DATA:
            begin
                wr_addr = offset_plus(rec_offset, data_done);
                data_done = data_done + 16'd1;
                if (data_done >= rec_len)
                begin
                    st = ST_OFFSET;
                    rec_offset = '0;
                    data_done = '0;
                end
                queue_result(ips_psp_pkg::KIND_WRITE, wr_addr, b, '0);
            end
            ST_RUN:
            begin
                if (field_idx < 3'd2)
                begin
                    rec_len = {rec_len[7:0], b};
                    field_idx = field_idx + 3'd1;
                end
                else
                begin
                    // fill value closes the run, even a zero-count one
                    field_idx = '0;
                    st = ST_OFFSET;
                    note_record_end(offset_plus(rec_offset, rec_len));
                    queue_result(ips_psp_pkg::KIND_FILL, {1'b0, rec_offset}, b, rec_len);
                    rec_offset = '0;
                end
            end
            default:
            begin
                // after end of patch or a bad header every byte is ignored
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [ips_psp_pkg::ADDR_W-1:0] want,
                               input logic [ips_psp_pkg::ADDR_W-1:0] got);
        if (got !== want)
        begin
            fails++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    task automatic check_result();
        ips_psp_pkg::result_t want;
        if (patch_results_due.size() == 0)
        begin
            fails++;
            $error("result request with none due: kind %0d address 0x%0h", kind, address);
        end
        else
        begin
            want = patch_results_due.pop_front();
            check_field("kind", want.kind, kind);
            check_field("address", want.address, address);
            check_field("value", want.value, value);
            check_field("run_count", want.run_count, run_count);
            check_field("image_size", want.image_size, image_size);
        end
    endtask

    // watch the three channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st = ST_HEADER;
            field_idx = '0;
            rec_offset = '0;
            rec_len = '0;
            data_done = '0;
            highest_end = '0;
            header_ok = 1'b1;
            base_size = ips_psp_pkg::BASE_SIZE_RESET;
            patch_results_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_size = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                parse_patch_byte(file_byte);
            end
            if (out_valid && !out_stall)
            begin
                check_result();
            end
        end
        mismatch_count <= fails;
        results_due <= patch_results_due.size();
    end

endmodule

// ----- tb/tb_ips_patch_stream_parser.sv -----
`timescale 1ns / 1ps
// top of the patch stream parser testbench: clock, reset, byte and config
// requests, result stalls and the verdict; depends on ips_psp_pkg, the parser
// and ips_psp_result_checker
module tb_ips_patch_stream_parser;

    localparam logic [39:0] MAGIC = "PATCH";
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 200;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [ips_psp_pkg::BYTE_W-1:0] file_byte = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [ips_psp_pkg::KIND_W-1:0] kind;
    logic [ips_psp_pkg::ADDR_W-1:0] address;
    logic [ips_psp_pkg::BYTE_W-1:0] value;
    logic [ips_psp_pkg::LEN_W-1:0]  run_count;
    logic [ips_psp_pkg::ADDR_W-1:0] image_size;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ips_psp_pkg::ADDR_W-1:0] cfg_data = '0;

    int mismatch_count;
    int results_due;
    int bytes_sent = 0;
    int hold_asks = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit bad_header;

    ips_patch_stream_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .file_byte  (file_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .address    (address),
        .value      (value),
        .run_count  (run_count),
        .image_size (image_size),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    ips_psp_result_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .file_byte      (file_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .address        (address),
        .value          (value),
        .run_count      (run_count),
        .image_size     (image_size),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_ips_patch_stream_parser: done, errors");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // result-side stalls, with a long hold-off on request
    initial
    begin : stall_gen
        int  run_left;
        int  hold_left;
        int  hold_seen;
        bit  stalling;
        run_left = 0;
        hold_left = 0;
        hold_seen = 0;
        stalling = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalling = ($urandom_range(0, 2) == 0);
                    run_left = stalling ? pick_stall() : $urandom_range(1, 12);
                end
                run_left--;
                out_stall <= stalling;
            end
        end
    end

    // one byte request, held until accepted
    task automatic send_byte(input logic [ips_psp_pkg::BYTE_W-1:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        file_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_u16(input logic [15:0] v);
        send_byte(v[15:8]);
        send_byte(v[7:0]);
    endtask

    task automatic send_u24(input logic [23:0] v);
        send_byte(v[23:16]);
        send_u16(v[15:0]);
    endtask

    task automatic send_data_record(input logic [ips_psp_pkg::OFFS_W-1:0] offs, input int len);
        send_u24(offs);
        send_u16(len[15:0]);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_run_record(input logic [ips_psp_pkg::OFFS_W-1:0] offs,
                                   input logic [ips_psp_pkg::LEN_W-1:0]  count,
                                   input logic [ips_psp_pkg::BYTE_W-1:0] fill);
        send_u24(offs);
        send_u16(16'h0000);
        send_u16(count);
        send_byte(fill);
    endtask

    // random record: mostly short data records, some runs, offsets near the
    // 24-bit top and near the end marker
    task automatic send_random_record();
        logic [ips_psp_pkg::OFFS_W-1:0] offs;
        logic [7:0]                     r8;
        logic [ips_psp_pkg::LEN_W-1:0]  count;
        int                             pick;
        int                             len;
        r8 = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        case (pick)
            0:       offs = '0;
            1:       offs = 24'hFFFFFF - 24'($urandom_range(0, 15));
            2:       offs = {ips_psp_pkg::EOF_MARK[23:8], r8};
            3:       offs = {ips_psp_pkg::EOF_MARK[23:16], r8, ips_psp_pkg::EOF_MARK[7:0]};
            default: offs = 24'($urandom_range(0, 24'hFFFFFF));
        endcase
        if (offs == ips_psp_pkg::EOF_MARK)
        begin
            offs[0] = ~offs[0];
        end
        if ($urandom_range(0, 4) == 0)
        begin
            pick = $urandom_range(0, 3);
            count = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF
                                                         : 16'($urandom_range(0, 65535));
            send_run_record(offs, count, 8'($urandom_range(0, 255)));
        end
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = $urandom_range(255, 257);
            else if (pick < 3)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(1, 6);
            send_data_record(offs, len);
        end
    endtask

    task automatic send_records_until(input int target);
        while (bytes_sent < target) send_random_record();
    endtask

    // wait until no result is due and the pipe has emptied
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_base_size(input logic [ips_psp_pkg::ADDR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int          bad_pos;
        logic [7:0]  c;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_base_size('0);

        // a bad header ends the stream for good, so only some runs take it
        bad_header = ($urandom_range(0, 7) == 0);
        bad_pos = $urandom_range(0, 4);
        for (int i = 0; i < 5; i++)
        begin
            c = MAGIC[8*(4-i) +: 8];
            if (bad_header && i == bad_pos)
            begin
                c = c ^ 8'($urandom_range(1, 255));
            end
            send_byte(c);
        end

        if (bad_header)
        begin
            // everything after the bad header is ignored, the header text too
            for (int i = 0; i < 5; i++)
            begin
                send_byte(MAGIC[8*(4-i) +: 8]);
            end
            repeat (3)
            begin
                repeat (245) send_byte(8'($urandom_range(0, 255)));
                drain_results();
                write_base_size(25'($urandom_range(0, 25'h1FFFFFF)));
            end
            write_base_size(25'h1FFFFFF);
        end
        else
        begin
            // directed: lowest offset, top offset with a full-count run,
            // zero-count run just past the end marker
            send_data_record(24'h000000, 1);
            send_run_record(24'hFFFFFF, 16'hFFFF, 8'hFF);
            send_run_record(ips_psp_pkg::EOF_MARK + 24'd1, 16'h0000, 8'h00);
            drain_results();
            write_base_size(25'h1FFFFFF);

            send_records_until(250);
            drain_results();
            write_base_size(25'($urandom_range(0, 25'h1FFFFFF)));

            // long result hold-off while data requests keep coming
            hold_asks++;
            quiet = 1'b1;
            send_data_record(24'($urandom_range(0, 24'hFFFFFF)), 30);
            quiet = 1'b0;
            send_records_until(450);
            drain_results();
            write_base_size(25'h100);

            // a stretch with no idling at all
            quiet = 1'b1;
            send_records_until(600);
            quiet = 1'b0;
            send_records_until(730);
            drain_results();
            write_base_size('0);

            // end marker, then bytes that must be ignored
            send_u24(ips_psp_pkg::EOF_MARK);
            repeat (12) send_byte(8'($urandom_range(0, 255)));
        end

        drain_results();
        if (mismatch_count == 0 && results_due == 0)
        begin
            $display("tb_ips_patch_stream_parser: done, clean");
        end
        else
        begin
            $display("tb_ips_patch_stream_parser: done, errors");
        end
        $finish;
    end

endmodule
